@@ rtl/mava_pkg.sv @@
`timescale 1ns / 1ps

package mava_pkg;

	localparam int COORD_BITS         = 12;
	localparam int MAX_TRIANGLES_LOG2 = 16;

	// internal coordinate width, wider than COORD_BITS, and its edge width
	localparam int CRD_W   = 14;
	localparam int EDGE_W  = CRD_W + 1;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int TRIP_W  = 48;
	localparam int AREA_W  = 48;
	localparam int VOL_W   = 56;
	localparam int VABS_W  = 55;
	localparam int CNT_W   = MAX_TRIANGLES_LOG2 + 1;
	localparam int SQ_W    = 64;
	localparam int ROOT_IN = 32;

	typedef struct packed {
		logic [COORD_BITS-1:0] v0_x;
		logic [COORD_BITS-1:0] v0_y;
		logic [COORD_BITS-1:0] v0_z;
		logic [COORD_BITS-1:0] v1_x;
		logic [COORD_BITS-1:0] v1_y;
		logic [COORD_BITS-1:0] v1_z;
		logic [COORD_BITS-1:0] v2_x;
		logic [COORD_BITS-1:0] v2_y;
		logic [COORD_BITS-1:0] v2_z;
		logic                  last_triangle;
	} tri_word_t;

	typedef struct packed {
		logic [AREA_W-1:0] twice_area;
		logic [VABS_W-1:0] six_volume;
		logic [CNT_W-1:0]  triangle_count;
		logic              overflow;
	} sum_word_t;

	// classified triangle: vertices (v0..v2, x y z) and edges e1, e2
	typedef struct packed {
		logic [8:0][CRD_W-1:0]  p;
		logic [5:0][EDGE_W-1:0] e;
		logic                   last;
	} tri_entry_t;

endpackage

@@ rtl/mava_front.sv @@
`timescale 1ns / 1ps

module mava_front (
	input  mava_pkg::tri_word_t  word,
	output mava_pkg::tri_entry_t entry
);

	localparam logic [mava_pkg::CRD_W-1:0] MASK =
		mava_pkg::CRD_W'((1 << mava_pkg::COORD_BITS) - 1);

	logic [mava_pkg::CRD_W-1:0] raw [9];
	logic [mava_pkg::CRD_W-1:0] p [9];

	assign raw[0] = mava_pkg::CRD_W'(word.v0_x);
	assign raw[1] = mava_pkg::CRD_W'(word.v0_y);
	assign raw[2] = mava_pkg::CRD_W'(word.v0_z);
	assign raw[3] = mava_pkg::CRD_W'(word.v1_x);
	assign raw[4] = mava_pkg::CRD_W'(word.v1_y);
	assign raw[5] = mava_pkg::CRD_W'(word.v1_z);
	assign raw[6] = mava_pkg::CRD_W'(word.v2_x);
	assign raw[7] = mava_pkg::CRD_W'(word.v2_y);
	assign raw[8] = mava_pkg::CRD_W'(word.v2_z);

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			// sign-extend from COORD_BITS, drop higher bits
			if (raw[i][mava_pkg::COORD_BITS-1]) begin
				p[i] = (raw[i] & MASK) | ~MASK;
			end else begin
				p[i] = raw[i] & MASK;
			end
			entry.p[i] = p[i];
		end
		for (int k = 0; k < 3; k++) begin
			entry.e[k]   = mava_pkg::EDGE_W'(signed'(p[k + 3])) -
				mava_pkg::EDGE_W'(signed'(p[k]));
			entry.e[k+3] = mava_pkg::EDGE_W'(signed'(p[k + 6])) -
				mava_pkg::EDGE_W'(signed'(p[k]));
		end
		entry.last = word.last_triangle;
	end

endmodule

@@ rtl/mava_queue.sv @@
`timescale 1ns / 1ps

module mava_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_stall,
	input  mava_pkg::tri_entry_t push_entry,
	output logic                 pop_valid,
	input  logic                 pop_stall,
	output mava_pkg::tri_entry_t pop_entry
);

	mava_pkg::tri_entry_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_stall = (fill_q == 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_entry  = mem_q[rd_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/mava_back.sv @@
`timescale 1ns / 1ps

module mava_back #(
	parameter int AREA_FRAC_BITS     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_stall,
	input  mava_pkg::tri_entry_t q_entry,
	output logic                 sum_valid,
	input  logic                 sum_stall,
	output mava_pkg::sum_word_t  sums
);

	localparam int RT_W  = mava_pkg::ROOT_IN + AREA_FRAC_BITS;
	localparam int REM_W = RT_W + 4;
	localparam int IT_W  = $clog2(RT_W + 1);
	localparam int CT_W  = mava_pkg::CNT_W;
	localparam int LAST_STEP = 18;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [mava_pkg::AREA_W:0] AREA_MAX = {1'b0, {mava_pkg::AREA_W{1'b1}}};
	localparam logic signed [mava_pkg::VOL_W:0] VOL_MAX =
		{2'b00, {(mava_pkg::VOL_W - 1){1'b1}}};
	localparam logic signed [mava_pkg::VOL_W:0] VOL_MIN = ~VOL_MAX;
	localparam logic [CT_W-1:0] COUNT_MAX = {1'b1, {mava_pkg::MAX_TRIANGLES_LOG2{1'b0}}};

	logic [2:0] state_q;
	logic [4:0] step_q;
	logic [IT_W-1:0] iter_q;

	logic signed [mava_pkg::CRD_W-1:0]  p_q [9];
	logic signed [mava_pkg::EDGE_W-1:0] e_q [6];
	logic last_q;

	logic signed [mava_pkg::MUL_W-1:0]  a_mux;
	logic signed [mava_pkg::MUL_W-1:0]  b_mux;
	logic signed [mava_pkg::PROD_W-1:0] prod_s1;
	logic signed [mava_pkg::MUL_W-1:0]  prod_lo;
	logic signed [mava_pkg::MUL_W-1:0]  t_q;
	logic signed [mava_pkg::MUL_W-1:0]  c_q [3];
	logic signed [mava_pkg::MUL_W-1:0]  m_q [3];
	logic [mava_pkg::SQ_W-1:0]          sumsq_q;
	logic signed [mava_pkg::TRIP_W-1:0] trip_q;

	logic [mava_pkg::SQ_W-1:0] x_q;
	logic [REM_W-1:0] rem_q;
	logic [RT_W-1:0]  root_q;
	logic [REM_W-1:0] rem_n;
	logic [REM_W-1:0] trial;

	logic [mava_pkg::AREA_W-1:0]       area_q;
	logic signed [mava_pkg::VOL_W-1:0] vol_q;
	logic [CT_W-1:0]                   count_q;
	logic                              sat_q;
	logic [mava_pkg::AREA_W:0]         area_n;
	logic signed [mava_pkg::VOL_W:0]   vol_n;

	logic                 sum_valid_q;
	mava_pkg::sum_word_t  sums_q;
	logic                 emit_go;
	logic [mava_pkg::VABS_W-1:0] vabs;
	logic                 vovf;
	logic [mava_pkg::VOL_W-1:0]  vneg;

	assign q_stall   = (state_q != ST_IDLE);
	assign sum_valid = sum_valid_q;
	assign sums      = sums_q;
	assign emit_go   = (state_q == ST_EMIT) && (!sum_valid_q || !sum_stall);
	assign prod_lo   = prod_s1[mava_pkg::MUL_W-1:0];

	// operand select for the shared multiplier
	always_comb begin
		a_mux = '0;
		b_mux = '0;
		case (step_q)
			5'd0:  begin a_mux = 32'(e_q[1]); b_mux = 32'(e_q[5]); end
			5'd1:  begin a_mux = 32'(e_q[2]); b_mux = 32'(e_q[4]); end
			5'd2:  begin a_mux = 32'(e_q[2]); b_mux = 32'(e_q[3]); end
			5'd3:  begin a_mux = 32'(e_q[0]); b_mux = 32'(e_q[5]); end
			5'd4:  begin a_mux = 32'(e_q[0]); b_mux = 32'(e_q[4]); end
			5'd5:  begin a_mux = 32'(e_q[1]); b_mux = 32'(e_q[3]); end
			5'd6:  begin a_mux = c_q[0]; b_mux = c_q[0]; end
			5'd7:  begin a_mux = c_q[1]; b_mux = c_q[1]; end
			5'd8:  begin a_mux = c_q[2]; b_mux = c_q[2]; end
			5'd9:  begin a_mux = 32'(p_q[4]); b_mux = 32'(p_q[8]); end
			5'd10: begin a_mux = 32'(p_q[5]); b_mux = 32'(p_q[7]); end
			5'd11: begin a_mux = 32'(p_q[3]); b_mux = 32'(p_q[8]); end
			5'd12: begin a_mux = 32'(p_q[5]); b_mux = 32'(p_q[6]); end
			5'd13: begin a_mux = 32'(p_q[3]); b_mux = 32'(p_q[7]); end
			5'd14: begin a_mux = 32'(p_q[4]); b_mux = 32'(p_q[6]); end
			5'd15: begin a_mux = 32'(p_q[0]); b_mux = m_q[0]; end
			5'd16: begin a_mux = 32'(p_q[1]); b_mux = m_q[1]; end
			5'd17: begin a_mux = 32'(p_q[2]); b_mux = m_q[2]; end
			default: begin a_mux = '0; b_mux = '0; end
		endcase
	end

	always_comb begin
		rem_n = {rem_q[REM_W-3:0], x_q[mava_pkg::SQ_W-1 -: 2]};
		trial = REM_W'({root_q, 2'b01});
	end

	always_comb begin
		area_n = (mava_pkg::AREA_W + 1)'(area_q) + (mava_pkg::AREA_W + 1)'(root_q);
		vol_n  = (mava_pkg::VOL_W + 1)'(vol_q) + (mava_pkg::VOL_W + 1)'(trip_q);
	end

	always_comb begin
		vneg = mava_pkg::VOL_W'(-vol_q);
		vovf = 1'b0;
		if (vol_q[mava_pkg::VOL_W-1]) begin
			if (vol_q == VOL_MIN[mava_pkg::VOL_W-1:0]) begin
				vabs = {mava_pkg::VABS_W{1'b1}};
				vovf = 1'b1;
			end else begin
				vabs = vneg[mava_pkg::VABS_W-1:0];
			end
		end else begin
			vabs = vol_q[mava_pkg::VABS_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= a_mux * b_mux;
		if (state_q == ST_IDLE && q_valid) begin
			for (int i = 0; i < 9; i++) begin
				p_q[i] <= signed'(q_entry.p[i]);
			end
			for (int i = 0; i < 6; i++) begin
				e_q[i] <= signed'(q_entry.e[i]);
			end
			last_q <= q_entry.last;
		end
		if (state_q == ST_MUL) begin
			// consume the product issued in the previous step
			case (step_q)
				5'd1, 5'd3, 5'd5, 5'd10, 5'd12, 5'd14: t_q <= prod_lo;
				5'd2:  c_q[0] <= t_q - prod_lo;
				5'd4:  c_q[1] <= t_q - prod_lo;
				5'd6:  c_q[2] <= t_q - prod_lo;
				5'd7:  sumsq_q <= prod_s1;
				5'd8, 5'd9: sumsq_q <= sumsq_q + prod_s1;
				5'd11: m_q[0] <= t_q - prod_lo;
				5'd13: m_q[1] <= t_q - prod_lo;
				5'd15: m_q[2] <= t_q - prod_lo;
				5'd16: trip_q <= prod_s1[mava_pkg::TRIP_W-1:0];
				5'd17: trip_q <= trip_q - prod_s1[mava_pkg::TRIP_W-1:0];
				5'd18: trip_q <= trip_q + prod_s1[mava_pkg::TRIP_W-1:0];
				default: ;
			endcase
			if (step_q == 5'(LAST_STEP)) begin
				x_q    <= sumsq_q;
				rem_q  <= '0;
				root_q <= '0;
			end
		end
		if (state_q == ST_ROOT) begin
			x_q <= x_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[RT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[RT_W-2:0], 1'b0};
			end
		end
		if (emit_go) begin
			sums_q.twice_area     <= area_q;
			sums_q.six_volume     <= vabs;
			sums_q.triangle_count <= mava_pkg::CNT_W'(count_q);
			sums_q.overflow       <= sat_q || vovf;
		end
	end

	// control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			iter_q      <= '0;
			area_q      <= '0;
			vol_q       <= '0;
			count_q     <= '0;
			sat_q       <= 1'b0;
			sum_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				sum_valid_q <= 1'b1;
			end else if (!sum_stall) begin
				sum_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (step_q == 5'(LAST_STEP)) begin
						state_q <= ST_ROOT;
						iter_q  <= '0;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_ROOT: begin
					if (iter_q == IT_W'(RT_W - 1)) begin
						state_q <= ST_ACC;
					end else begin
						iter_q <= iter_q + IT_W'(1);
					end
				end
				ST_ACC: begin
					if (area_n > AREA_MAX) begin
						area_q <= AREA_MAX[mava_pkg::AREA_W-1:0];
						sat_q  <= 1'b1;
					end else begin
						area_q <= area_n[mava_pkg::AREA_W-1:0];
					end
					if (vol_n > VOL_MAX) begin
						vol_q <= VOL_MAX[mava_pkg::VOL_W-1:0];
						sat_q <= 1'b1;
					end else if (vol_n < VOL_MIN) begin
						vol_q <= VOL_MIN[mava_pkg::VOL_W-1:0];
						sat_q <= 1'b1;
					end else begin
						vol_q <= vol_n[mava_pkg::VOL_W-1:0];
					end
					if (count_q >= COUNT_MAX) begin
						count_q <= COUNT_MAX;
						sat_q   <= 1'b1;
					end else begin
						count_q <= count_q + CT_W'(1);
					end
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					// hold until the output register is free, then clear
					if (emit_go) begin
						area_q  <= '0;
						vol_q   <= '0;
						count_q <= '0;
						sat_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/mesh_area_volume_accumulator.sv @@
`timescale 1ns / 1ps
// Pacing: the back end takes a new triangle only once it is back in idle, set by the
// 19-step shared multiplier sequence and the 32 + AREA_FRAC_BITS step bit-serial square
// root, one bit per cycle, plus the emit state on a last triangle.
// The result word of a mesh is registered as its last triangle leaves the emit state.
// A two-entry queue takes new triangles while the back end is busy.
// Reset: arst_n clears all sums, the count, the queue and the output valid.

module mesh_area_volume_accumulator #(
	parameter int AREA_FRAC_BITS     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tri_valid,
	output logic                tri_stall,
	input  mava_pkg::tri_word_t tri_word,
	output logic                sum_valid,
	input  logic                sum_stall,
	output mava_pkg::sum_word_t sums
);

	mava_pkg::tri_entry_t front_entry;
	mava_pkg::tri_entry_t back_entry;
	logic                 back_valid;
	logic                 back_stall;

	mava_front u_front (
		.word  (tri_word),
		.entry (front_entry)
	);

	mava_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (tri_valid),
		.push_stall (tri_stall),
		.push_entry (front_entry),
		.pop_valid  (back_valid),
		.pop_stall  (back_stall),
		.pop_entry  (back_entry)
	);

	mava_back #(
		.AREA_FRAC_BITS     (AREA_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (back_valid),
		.q_stall   (back_stall),
		.q_entry   (back_entry),
		.sum_valid (sum_valid),
		.sum_stall (sum_stall),
		.sums      (sums)
	);

endmodule

@@ rtl/mava_checker.sv @@
`timescale 1ns / 1ps

module mava_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                sum_valid,
	input logic                sum_stall,
	input mava_pkg::sum_word_t sums
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(sums))
		else $error("result word changed while stalled");

	// a result always counts the last triangle and never passes the count limit
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> (sums.triangle_count != '0) &&
		(32'(sums.triangle_count) <= (32'd1 << mava_pkg::MAX_TRIANGLES_LOG2)))
		else $error("triangle count out of range");

	// no result word in the first cycle out of reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !sum_valid)
		else $error("result valid right after reset");

endmodule

bind mesh_area_volume_accumulator mava_checker u_mava_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.sum_valid (sum_valid),
	.sum_stall (sum_stall),
	.sums      (sums)
);

@@ verif/mesh_area_volume_accumulator_tb.sv @@
`timescale 1ns / 1ps

module mesh_area_volume_accumulator_tb;

	localparam longint AREA_TOP  = (64'd1 << 48) - 1;
	localparam longint VOL_TOP   = (64'sd1 <<< 55) - 1;
	localparam longint VOL_FLOOR = -VOL_TOP - 1;
	localparam longint CNT_TOP   = 64'd1 << 16;
	localparam int     FRAC      = 4;
	localparam int     DRAIN     = 200;
	localparam int     STALL_LIMIT = 20000;

	localparam logic [11:0] CMAX = 12'h7ff;
	localparam logic [11:0] CMIN = 12'h800;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                tri_valid = 1'b0;
	logic                tri_stall;
	mava_pkg::tri_word_t tri_word = '0;
	logic                sum_valid;
	logic                sum_stall = 1'b0;
	mava_pkg::sum_word_t sums;

	mesh_area_volume_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_stall(tri_stall), .tri_word(tri_word),
		.sum_valid(sum_valid), .sum_stall(sum_stall), .sums(sums)
	);

	always #2 clk = ~clk;

	// running mesh sums held by the predictor
	longint unsigned area_acc;
	longint          vol_acc;
	longint unsigned tri_cnt;
	bit              sat_seen;

	mava_pkg::sum_word_t expected_sums[$];
	int        mismatches = 0;
	int        results_seen = 0;
	bit        sender_done = 1'b0;
	bit        quiet_sides = 1'b0;
	bit        hold_sink = 1'b0;
	int        idle_cycles = 0;

	function automatic longint unsigned isqrt_scaled(longint unsigned x);
		longint unsigned root, rem, trial, pair;
		root = 0;
		rem = 0;
		for (int i = 0; i < 32 + FRAC; i++) begin
			pair = (i < 32) ? ((x >> (62 - 2 * i)) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic longint unsigned sqr(longint v);
		longint unsigned a;
		a = (v < 0) ? -v : v;
		return a * a;
	endfunction

	function automatic void clear_mesh();
		area_acc = 0;
		vol_acc = 0;
		tri_cnt = 0;
		sat_seen = 1'b0;
	endfunction

	// fold one triangle into the mesh sums; queue the totals on the last one
	function automatic void accumulate_triangle(mava_pkg::tri_word_t w);
		longint p[9];
		longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz, trip;
		longint unsigned vabs;
		bit ovf;
		mava_pkg::sum_word_t s;
		p[0] = longint'($signed(w.v0_x)); p[1] = longint'($signed(w.v0_y));
		p[2] = longint'($signed(w.v0_z)); p[3] = longint'($signed(w.v1_x));
		p[4] = longint'($signed(w.v1_y)); p[5] = longint'($signed(w.v1_z));
		p[6] = longint'($signed(w.v2_x)); p[7] = longint'($signed(w.v2_y));
		p[8] = longint'($signed(w.v2_z));
		e1x = p[3] - p[0]; e1y = p[4] - p[1]; e1z = p[5] - p[2];
		e2x = p[6] - p[0]; e2y = p[7] - p[1]; e2z = p[8] - p[2];
		cx = e1y * e2z - e1z * e2y;
		cy = e1z * e2x - e1x * e2z;
		cz = e1x * e2y - e1y * e2x;
		trip = p[0] * (p[4] * p[8] - p[5] * p[7])
		     - p[1] * (p[3] * p[8] - p[5] * p[6])
		     + p[2] * (p[3] * p[7] - p[4] * p[6]);
		area_acc += isqrt_scaled(sqr(cx) + sqr(cy) + sqr(cz));
		if (area_acc > AREA_TOP) begin
			area_acc = AREA_TOP;
			sat_seen = 1'b1;
		end
		vol_acc += trip;
		if (vol_acc > VOL_TOP) begin
			vol_acc = VOL_TOP;
			sat_seen = 1'b1;
		end else if (vol_acc < VOL_FLOOR) begin
			vol_acc = VOL_FLOOR;
			sat_seen = 1'b1;
		end
		if (tri_cnt >= CNT_TOP) begin
			tri_cnt = CNT_TOP;
			sat_seen = 1'b1;
		end else begin
			tri_cnt++;
		end
		if (!w.last_triangle)
			return;
		ovf = sat_seen;
		if (vol_acc == VOL_FLOOR) begin
			vabs = VOL_TOP;
			ovf = 1'b1;
		end else begin
			vabs = (vol_acc < 0) ? -vol_acc : vol_acc;
		end
		s.twice_area = area_acc[47:0];
		s.six_volume = vabs[54:0];
		s.triangle_count = tri_cnt[16:0];
		s.overflow = ovf;
		expected_sums.insert(expected_sums.size(), s);
		clear_mesh();
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// directed rows
	typedef struct {
		mava_pkg::tri_word_t w;
		bit                  fixed;
		mava_pkg::sum_word_t want;
	} dir_row_t;

	dir_row_t rows[$];

	function automatic mava_pkg::tri_word_t mk(logic [11:0] a, b, c, d, e, f, g, h, i,
		logic l);
		mava_pkg::tri_word_t w;
		w = {a, b, c, d, e, f, g, h, i, l};
		return w;
	endfunction

	function automatic void add_row(mava_pkg::tri_word_t w, bit fx = 0,
		mava_pkg::sum_word_t want = '0);
		dir_row_t r;
		r.w = w;
		r.fixed = fx;
		r.want = want;
		rows.insert(rows.size(), r);
	endfunction

	function automatic mava_pkg::tri_word_t rand_tri(bit l, int span);
		mava_pkg::tri_word_t w;
		logic [11:0] c[9];
		for (int i = 0; i < 9; i++)
			c[i] = (span >= 2048) ? 12'($urandom) : 12'($urandom_range(2 * span) - span);
		w = mk(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], l);
		return w;
	endfunction

	task automatic send_triangle(mava_pkg::tri_word_t w);
		while (!quiet_sides && $urandom_range(99) < 14) begin
			tri_valid <= 1'b0;
			@(posedge clk);
		end
		tri_valid <= 1'b1;
		tri_word <= w;
		@(posedge clk);
		while (tri_stall)
			@(posedge clk);
		accumulate_triangle(w);
	endtask

	task automatic wait_drained();
		tri_valid <= 1'b0;
		@(posedge clk);
		while (expected_sums.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		clear_mesh();
		@(posedge clk);

		// degenerate single triangle
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, '{0, 0, 1, 0});
		// unit right triangle with origin: |c| = 1 -> 16, triple 0
		add_row(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 1), 1, '{16, 0, 1, 0});
		// unit axes: |c|^2 = 3, triple = 1
		add_row(mk(1, 0, 0, 0, 1, 0, 0, 0, 1, 1), 1, '{27, 1, 1, 0});
		// extremes of the coordinates
		add_row(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1), 1, '{0, 0, 1, 0});
		add_row(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1), 1, '{0, 0, 1, 0});
		add_row(mk(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX, 1));
		add_row(mk(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN, 1));
		add_row(mk(CMIN, CMIN, 0, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1));
		add_row(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1));
		// multi-triangle mesh with sign cancel
		add_row(mk(5, 0, 0, 0, 5, 0, 0, 0, 5, 0));
		add_row(mk(5, 0, 0, 0, 0, 5, 0, 5, 0, 1));
		add_row(mk(12'hfff, 3, 7, 100, 12'hf00, 12'h0aa, 12'h555, 9, 12'hccc, 0));
		add_row(mk(12'h123, 12'h456, 12'h789, 12'habc, 12'hdef, 12'h010, 7, 8, 9, 1));
		foreach (rows[k]) begin
			send_triangle(rows[k].w);
			if (rows[k].fixed)
				expected_sums[expected_sums.size() - 1] = rows[k].want;
		end
		wait_drained();

		// long mesh of the largest negative triple products
		for (int k = 0; k < 20; k++)
			send_triangle(mk(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN, 0));
		send_triangle(mk(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN, 1));
		// another long mesh of large same-sign triple products
		for (int k = 0; k < 20; k++)
			send_triangle(mk(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMIN, 0));
		send_triangle(mk(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMIN, 1));

		// receiver holds off while triangles keep coming
		hold_sink = 1'b1;
		for (int k = 0; k < 12; k++)
			send_triangle(rand_tri(k % 2, 2048));
		hold_sink = 1'b0;
		wait_drained();

		// random meshes, mostly small ones
		for (int k = 0; k < 380; k++) begin
			if (k == 150)
				quiet_sides = 1'b1;
			if (k == 230)
				quiet_sides = 1'b0;
			if (k == 300)
				wait_drained();
			send_triangle(rand_tri($urandom_range(3) == 0,
				($urandom_range(1) == 0) ? 2048 : $urandom_range(60) + 1));
		end
		send_triangle(rand_tri(1, 2048));
		tri_valid <= 1'b0;
		sender_done = 1'b1;
	end

	// result side: random stall plus one long hold-off
	always @(posedge clk) begin
		if (hold_sink) begin
			sum_stall <= 1'b1;
		end else if (quiet_sides) begin
			sum_stall <= 1'b0;
		end else begin
			sum_stall <= ($urandom_range(99) < 14);
		end
	end

	// long hold-off counted here, released after a fixed stretch
	initial begin
		wait (hold_sink);
		repeat (800) @(posedge clk);
		hold_sink = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && sum_valid && !sum_stall) begin
			results_seen++;
			if (expected_sums.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				mava_pkg::sum_word_t e;
				e = expected_sums.pop_front();
				if (sums.twice_area !== e.twice_area)
					report_mismatch("twice_area", sums.twice_area, e.twice_area);
				if (sums.six_volume !== e.six_volume)
					report_mismatch("six_volume", sums.six_volume, e.six_volume);
				if (sums.triangle_count !== e.triangle_count)
					report_mismatch("triangle_count", sums.triangle_count, e.triangle_count);
				if (sums.overflow !== e.overflow)
					report_mismatch("overflow", sums.overflow, e.overflow);
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((tri_valid && !tri_stall) || (sum_valid && !sum_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("mesh_area_volume_accumulator test failed");
			$finish;
		end
	end

	initial begin
		wait (sender_done);
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && expected_sums.size() == 0)
			$display("mesh_area_volume_accumulator test passed");
		else
			$display("mesh_area_volume_accumulator test failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/mava_pkg.sv
rtl/mava_front.sv
rtl/mava_queue.sv
rtl/mava_back.sv
rtl/mesh_area_volume_accumulator.sv
rtl/mava_checker.sv
verif/mesh_area_volume_accumulator_tb.sv
